// File: hdl/bhp_pkg.sv
// Shared types, constants and helper functions for the bucketed histogram
// percentile unit. No dependencies; every other file imports this package.
package bhp_pkg;

  localparam int MAX_BUCKETS_DEF = 64;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int QDEPTH          = 2;

  localparam logic [39:0] MASK40    = 40'hFF_FFFF_FFFF;
  localparam logic [40:0] MASK41    = 41'h1FF_FFFF_FFFF;
  localparam logic [63:0] ALL64     = 64'hFFFF_FFFF_FFFF_FFFF;

  // Percentile scale and its reciprocal: floor(t / 10000) for t below 2^30
  // is ((t >> 4) * PCT_RECIP) >> PCT_RECIP_SH.
  localparam logic [29:0] PCT_SCALE    = 30'd10000;
  localparam logic [26:0] PCT_RECIP    = 27'd109951163;
  localparam int          PCT_RECIP_SH = 36;

  typedef enum logic [1:0] {
    REQ_RECORD = 2'd0,
    REQ_PCTL   = 2'd1,
    REQ_BREAD  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    CFG_MODE      = 3'd0,
    CFG_TOTAL     = 3'd1,
    CFG_LIN_LOW   = 3'd2,
    CFG_LIN_WIDTH = 3'd3,
    CFG_EXP_SHIFT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [39:0] sample_value;
    logic [13:0] percent_hundredths;
    logic [5:0]  bucket_select;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  resp_kind;
    logic [63:0] count_out;
    logic [63:0] sum_out;
    logic [39:0] lower_bound_out;
    logic [40:0] upper_bound_out;
    logic        index_ok;
    logic [39:0] smallest_out;
    logic [39:0] largest_out;
    logic [39:0] mean_out;
    logic [40:0] percentile_out;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    logic     idx_ok;
  } q_entry_t;

  typedef struct packed {
    logic        mode;
    logic [6:0]  total;
    logic [39:0] lin_low;
    logic [39:0] lin_width;
    logic [3:0]  exp_shift;
  } cfg_t;

  typedef struct packed {
    logic         start;
    logic [127:0] num;
    logic [63:0]  den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  function automatic logic [63:0] bhp_sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ALL64 : s[63:0];
  endfunction

  function automatic logic [8:0] bhp_used(input logic [6:0] total, input int unsigned maxb);
    logic [8:0] t;
    logic [8:0] m;
    t = {2'b00, total};
    m = 9'(maxb);
    return (t < m) ? t : m;
  endfunction

  // Boundary j of the current spacing, saturated to 41 bits.
  function automatic logic [40:0] bhp_bound(input cfg_t cfg, input logic [8:0] j,
                                            input int unsigned frac);
    logic [48:0] prod;
    logic [49:0] lin;
    logic [12:0] sh;
    logic [40:0] res;
    prod = {9'b0, cfg.lin_width} * {40'b0, j};
    lin  = {10'b0, cfg.lin_low} + {1'b0, prod};
    sh   = 13'(frac) + ({9'b0, cfg.exp_shift} * {4'b0, j});
    if (!cfg.mode) begin
      res = (lin > {9'b0, MASK41}) ? MASK41 : lin[40:0];
    end else if (sh >= 13'd41) begin
      res = MASK41;
    end else begin
      res = 41'(1) << sh;
    end
    return res;
  endfunction

endpackage

// File: hdl/bucketed_histogram_percentile_unit.sv
// Top level of the bucketed histogram percentile unit: configuration
// registers and the front end, queue, back end and divider. Depends on bhp_pkg.
//
// Requests enter on start when busy is low; a front stage checks the bucket
// index and parks the request in a two-entry queue, so busy rises only when
// the queue is full. An accepted request passes the front stage register and
// the queue before it reaches the back end. The back end serves one request
// at a time and shows each result on out_result for exactly one cycle with
// out_valid high; there is no way to stall it, so the receiver must take
// every result as it comes. Every request is taken from the queue, does its
// own work, launches the 128-step bit-serial mean division and waits on it
// (skipped while the store is empty), and then presents the result. A record
// searches the buckets (the boundary compare walks the buckets one per cycle)
// until the hit or the last bucket, then reads and updates the bucket; a
// bucket read computes its lower and upper boundaries; a percentile
// multiplies, divides by 10000 through the reciprocal for the target, walks
// the buckets and, for the interpolation, computes the two boundaries,
// multiplies, launches the divider and waits on it. A clear empties the
// store through per-bucket valid bits. Configuration is taken at any time
// (cfg_ready is always high) but must only change while idle.
module bucketed_histogram_percentile_unit
  import bhp_pkg::*;
#(
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_result,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [39:0] cfg_data
);

  cfg_t     cfg_r;
  q_entry_t f_data, q_data;
  logic     f_push, q_full, q_empty, q_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;

  // Register writes: keep only the field width of each register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= 1'b0;
      cfg_r.total     <= '0;
      cfg_r.lin_low   <= '0;
      cfg_r.lin_width <= '0;
      cfg_r.exp_shift <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:      cfg_r.mode      <= cfg_data[0];
        CFG_TOTAL:     cfg_r.total     <= cfg_data[6:0];
        CFG_LIN_LOW:   cfg_r.lin_low   <= cfg_data;
        CFG_LIN_WIDTH: cfg_r.lin_width <= cfg_data;
        CFG_EXP_SHIFT: cfg_r.exp_shift <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  bhp_front #(.MAX_BUCKETS(MAX_BUCKETS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .push      (f_push),
    .push_data (f_data)
  );

  bhp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (f_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  bhp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  bhp_back #(.MAX_BUCKETS(MAX_BUCKETS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_data     (q_data),
    .q_empty    (q_empty),
    .pop        (q_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

// File: hdl/bhp_queue.sv
// Short FIFO of classified requests between front and back end.
// Depends on bhp_pkg.
module bhp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bhp_pkg::q_entry_t push_data,
  input  logic              pop,
  output bhp_pkg::q_entry_t pop_data,
  output logic              full,
  output logic              empty
);
  import bhp_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  q_entry_t        q_r [QDEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hdl/bhp_front.sv
// Front end: takes a request, checks the bucket index against the buckets
// in use and hands the entry to the queue. Depends on bhp_pkg.
module bhp_front #(
  parameter int MAX_BUCKETS = bhp_pkg::MAX_BUCKETS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bhp_pkg::in_item_t in_item,
  input  bhp_pkg::cfg_t     cfg,
  input  logic              q_full,
  output logic              push,
  output bhp_pkg::q_entry_t push_data
);
  import bhp_pkg::*;

  logic     stg_vld_r, stg_vld_nxt;
  q_entry_t stg_r;
  logic     take;
  logic [8:0] used;

  assign used = bhp_used(cfg.total, MAX_BUCKETS);
  assign push = stg_vld_r && !q_full;
  assign busy = stg_vld_r && q_full;
  assign take = start && !busy;
  assign push_data = stg_r;

  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (push) stg_vld_nxt = 1'b0;
    if (take) stg_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stg_r.item   <= in_item;
      stg_r.idx_ok <= ({3'b000, in_item.bucket_select} < used);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) stg_vld_r <= 1'b0;
    else        stg_vld_r <= stg_vld_nxt;
  end

endmodule

// File: hdl/bhp_div.sv
// Iterative restoring divider, 128 by 64 bits, one quotient bit per cycle.
// Depends on bhp_pkg.
module bhp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bhp_pkg::div_req_t req,
  output bhp_pkg::div_rsp_t rsp
);
  import bhp_pkg::*;

  logic         busy_r, done_r;
  logic [6:0]   cnt_r;
  logic [127:0] num_r;
  logic [63:0]  den_r, rem_r, quo_r;
  logic [63:0]  rem_sh;
  logic         top, qbit;

  assign top    = rem_r[63];
  assign rem_sh = {rem_r[62:0], num_r[127]};
  assign qbit   = top || (rem_sh >= den_r);

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[126:0], 1'b0};
      rem_r <= qbit ? rem_sh - den_r : rem_sh;
      quo_r <= {quo_r[62:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 7'd127) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/bhp_back.sv
// Back end: bucket store, totals and the sequencer that records, reads,
// clears and estimates percentiles. Depends on bhp_pkg and a bhp_div unit.
module bhp_back #(
  parameter int MAX_BUCKETS = bhp_pkg::MAX_BUCKETS_DEF,
  parameter int FRAC_BITS   = bhp_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bhp_pkg::cfg_t      cfg,
  input  bhp_pkg::q_entry_t  q_data,
  input  logic               q_empty,
  output logic               pop,
  output bhp_pkg::div_req_t  div_req,
  input  bhp_pkg::div_rsp_t  div_rsp,
  output logic               out_valid,
  output bhp_pkg::out_item_t out_result
);
  import bhp_pkg::*;

  localparam int AW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001, S_SINIT = 19'h00002, S_SRCH = 19'h00004,
    S_RRD  = 19'h00008, S_RWR   = 19'h00010, S_BLO  = 19'h00020,
    S_BHI  = 19'h00040, S_MUL   = 19'h00080, S_MULW = 19'h00100,
    S_TDA  = 19'h00200, S_TDB   = 19'h00400, S_DIVS = 19'h00800,
    S_DIV  = 19'h01000, S_PRD   = 19'h02000, S_PACC = 19'h04000,
    S_PLO  = 19'h08000, S_PHI   = 19'h10000, S_MEAN = 19'h20000,
    S_OUT  = 19'h40000
  } state_t;

  typedef enum logic [1:0] {D_TARGET, D_INTERP, D_MEAN} dsel_t;

  state_t state_r, state_nxt;
  dsel_t  dsel_r, dsel_nxt;

  q_entry_t    ent_r, ent_nxt;
  logic [8:0]  n_r, n_nxt, idx_r, idx_nxt;
  logic [40:0] bprev_r, bprev_nxt;
  logic [63:0] gc_r, gc_nxt, gs_r, gs_nxt;
  logic [39:0] min_r, min_nxt, max_r, max_nxt;
  logic [63:0] cum_r, cum_nxt, target_r, target_nxt;
  logic [63:0] csel_r, csel_nxt, before_r, before_nxt;
  logic [63:0] cnt_o_r, cnt_o_nxt, sum_o_r, sum_o_nxt;
  logic [39:0] lo_o_r, lo_o_nxt, mean_r, mean_nxt;
  logic [40:0] up_o_r, up_o_nxt, pct_r, pct_nxt;
  logic [63:0] ma_r, ma_nxt, mb_r, mb_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [79:0] pp_r;
  logic [1:0]  pk_r, mk_r, mk_nxt;
  logic        pv_r;
  logic [2:0]  tk_r, tk_nxt;
  logic [13:0] trem_r, trem_nxt;
  logic [15:0] tqd_r, tqd_nxt;
  logic [63:0] tq_r, tq_nxt;

  logic [63:0] cnt_mem [MAX_BUCKETS];
  logic [63:0] sum_mem [MAX_BUCKETS];
  logic [MAX_BUCKETS-1:0] vld_r;
  logic [63:0] rd_cnt_r, rd_sum_r;
  logic        rd_vld_r;
  logic [AW-1:0] addr;
  logic        wr_en, clr_en;
  logic [63:0] cntv, sumv, csum, part, width64;
  logic [8:0]  bnd_j;
  logic [40:0] bnd, width;
  logic [40:0] vext;
  logic        hit;
  logic [29:0] t_cur, tback, tdiff;
  logic [52:0] tprod;

  assign addr  = idx_r[AW-1:0];
  assign cntv  = rd_vld_r ? rd_cnt_r : '0;
  assign sumv  = rd_vld_r ? rd_sum_r : '0;
  assign vext  = {1'b0, ent_r.item.sample_value};
  assign csum  = bhp_sat_add(cum_r, cntv);
  assign bnd   = bhp_bound(cfg, bnd_j, FRAC_BITS);
  assign hit   = (vext >= bprev_r) && (vext < bnd);
  assign width = (bnd > bprev_r) ? bnd - bprev_r : '0;
  assign width64 = {23'b0, width};
  assign part  = (target_r > before_r) ? target_r - before_r : '0;

  // Target divide by 10000, 16 product bits per step: the running remainder
  // stays below 10000, so each step is a 30-bit reciprocal multiply.
  assign t_cur = {trem_r, acc_r[79:64]};
  assign tprod = {27'b0, t_cur[29:4]} * {26'b0, PCT_RECIP};
  assign tback = {14'b0, tqd_r} * PCT_SCALE;
  assign tdiff = t_cur - tback;

  always_comb begin
    case (state_r)
      S_SINIT:       bnd_j = '0;
      S_BLO, S_PLO:  bnd_j = idx_r;
      default:       bnd_j = idx_r + 1'b1;
    endcase
  end

  // Divider launch: interpolation after a multiply, or the mean.
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = acc_r;
    div_req.den   = csel_r;
    if (state_r == S_DIVS) begin
      div_req.start = 1'b1;
    end else if (state_r == S_MEAN && gc_r != '0) begin
      div_req.start = 1'b1;
      div_req.num   = {64'b0, gs_r};
      div_req.den   = gc_r;
    end
  end

  assign pop       = (state_r == S_IDLE) && !q_empty;
  assign wr_en     = (state_r == S_RWR);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    out_result.resp_kind       = ent_r.item.req_type;
    out_result.count_out       = (req_kind_t'(ent_r.item.req_type) == REQ_BREAD) ? cnt_o_r : gc_r;
    out_result.sum_out         = (req_kind_t'(ent_r.item.req_type) == REQ_BREAD) ? sum_o_r : gs_r;
    out_result.lower_bound_out = lo_o_r;
    out_result.upper_bound_out = up_o_r;
    out_result.index_ok        = ent_r.idx_ok;
    out_result.smallest_out    = min_r;
    out_result.largest_out     = max_r;
    out_result.mean_out        = mean_r;
    out_result.percentile_out  = pct_r;
  end

  always_comb begin
    state_nxt  = state_r;
    dsel_nxt   = dsel_r;
    ent_nxt    = ent_r;
    n_nxt      = n_r;
    idx_nxt    = idx_r;
    bprev_nxt  = bprev_r;
    gc_nxt     = gc_r;
    gs_nxt     = gs_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    cum_nxt    = cum_r;
    target_nxt = target_r;
    csel_nxt   = csel_r;
    before_nxt = before_r;
    cnt_o_nxt  = cnt_o_r;
    sum_o_nxt  = sum_o_r;
    lo_o_nxt   = lo_o_r;
    up_o_nxt   = up_o_r;
    mean_nxt   = mean_r;
    pct_nxt    = pct_r;
    ma_nxt     = ma_r;
    mb_nxt     = mb_r;
    mk_nxt     = mk_r;
    tk_nxt     = tk_r;
    trem_nxt   = trem_r;
    tqd_nxt    = tqd_r;
    tq_nxt     = tq_r;
    acc_nxt    = pv_r ? acc_r + ({48'b0, pp_r} << {pk_r, 4'b0000}) : acc_r;
    clr_en     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          ent_nxt  = q_data;
          n_nxt    = bhp_used(cfg.total, MAX_BUCKETS);
          lo_o_nxt = '0;
          up_o_nxt = '0;
          pct_nxt  = '0;
          case (req_kind_t'(q_data.item.req_type))
            REQ_RECORD: begin
              gc_nxt  = bhp_sat_add(gc_r, 64'd1);
              gs_nxt  = bhp_sat_add(gs_r, {24'b0, q_data.item.sample_value});
              if (q_data.item.sample_value < min_r) min_nxt = q_data.item.sample_value;
              if (q_data.item.sample_value > max_r) max_nxt = q_data.item.sample_value;
              idx_nxt   = '0;
              state_nxt = (n_nxt == '0) ? S_MEAN : S_SINIT;
            end
            REQ_CLEAR: begin
              clr_en    = 1'b1;
              gc_nxt    = '0;
              gs_nxt    = '0;
              min_nxt   = MASK40;
              max_nxt   = '0;
              state_nxt = S_MEAN;
            end
            REQ_BREAD: begin
              idx_nxt   = {3'b000, q_data.item.bucket_select};
              cnt_o_nxt = '0;
              sum_o_nxt = '0;
              state_nxt = q_data.idx_ok ? S_BLO : S_MEAN;
            end
            default: begin
              if (gc_r == '0) begin
                state_nxt = S_MEAN;
              end else begin
                ma_nxt    = gc_r;
                mb_nxt    = {50'b0, q_data.item.percent_hundredths};
                mk_nxt    = '0;
                acc_nxt   = '0;
                dsel_nxt  = D_TARGET;
                state_nxt = S_MUL;
              end
            end
          endcase
        end
      end
      S_SINIT: begin
        bprev_nxt = bnd;
        state_nxt = S_SRCH;
      end
      S_SRCH: begin
        if (hit || idx_r == n_r - 1'b1) begin
          state_nxt = S_RRD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          bprev_nxt = bnd;
        end
      end
      S_RRD: state_nxt = S_RWR;
      S_RWR: state_nxt = S_MEAN;
      S_BLO: begin
        bprev_nxt = bnd;
        state_nxt = S_BHI;
      end
      S_BHI: begin
        cnt_o_nxt = cntv;
        sum_o_nxt = sumv;
        lo_o_nxt  = (bprev_r > {1'b0, MASK40}) ? MASK40 : bprev_r[39:0];
        up_o_nxt  = bnd;
        state_nxt = S_MEAN;
      end
      S_MUL: begin
        mk_nxt = mk_r + 1'b1;
        if (mk_r == 2'd3) state_nxt = S_MULW;
      end
      S_MULW: begin
        tk_nxt    = '0;
        trem_nxt  = '0;
        state_nxt = (dsel_r == D_TARGET) ? S_TDA : S_DIVS;
      end
      S_TDA: begin
        tqd_nxt   = tprod[PCT_RECIP_SH +: 16];
        state_nxt = S_TDB;
      end
      S_TDB: begin
        trem_nxt = tdiff[13:0];
        tq_nxt   = {tq_r[47:0], tqd_r};
        acc_nxt  = acc_r << 16;
        tk_nxt   = tk_r + 1'b1;
        if (tk_r == 3'd4) begin
          // Top quotient digit nonzero: the target does not fit, saturate.
          target_nxt = (tq_r[63:48] != '0) ? ALL64 : {tq_r[47:0], tqd_r};
          cum_nxt    = '0;
          idx_nxt    = '0;
          if (n_r == '0) begin
            pct_nxt   = {1'b0, max_r};
            state_nxt = S_MEAN;
          end else begin
            state_nxt = S_PRD;
          end
        end else begin
          state_nxt = S_TDA;
        end
      end
      S_DIVS: state_nxt = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          case (dsel_r)
            D_INTERP: begin
              pct_nxt   = bprev_r + div_rsp.quo[40:0];
              state_nxt = S_MEAN;
            end
            default: begin
              mean_nxt  = (div_rsp.quo > {24'b0, MASK40}) ? MASK40 : div_rsp.quo[39:0];
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_PRD: state_nxt = S_PACC;
      S_PACC: begin
        cum_nxt = csum;
        if (csum >= target_r) begin
          csel_nxt   = cntv;
          before_nxt = cum_r;
          state_nxt  = S_PLO;
        end else if (idx_r == n_r - 1'b1) begin
          pct_nxt   = {1'b0, max_r};
          state_nxt = S_MEAN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_PLO: begin
        bprev_nxt = bnd;
        state_nxt = S_PHI;
      end
      S_PHI: begin
        if (csel_r == '0) begin
          pct_nxt   = bprev_r;
          state_nxt = S_MEAN;
        end else begin
          ma_nxt    = (part > csel_r) ? csel_r : part;
          mb_nxt    = width64;
          mk_nxt    = '0;
          acc_nxt   = '0;
          dsel_nxt  = D_INTERP;
          state_nxt = S_MUL;
        end
      end
      S_MEAN: begin
        if (gc_r == '0) begin
          mean_nxt  = '0;
          state_nxt = S_OUT;
        end else begin
          dsel_nxt  = D_MEAN;
          state_nxt = S_DIV;
        end
      end
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Partial products: one 16-bit slice of the multiplier per cycle.
  always_ff @(posedge clk) begin
    pp_r     <= ma_r * mb_r[{mk_r, 4'b0000} +: 16];
    pk_r     <= mk_r;
    rd_cnt_r <= cnt_mem[addr];
    rd_sum_r <= sum_mem[addr];
    if (wr_en) begin
      cnt_mem[addr] <= bhp_sat_add(cntv, 64'd1);
      sum_mem[addr] <= bhp_sat_add(sumv, {24'b0, ent_r.item.sample_value});
    end
  end

  always_ff @(posedge clk) begin
    ent_r    <= ent_nxt;
    n_r      <= n_nxt;
    idx_r    <= idx_nxt;
    bprev_r  <= bprev_nxt;
    cum_r    <= cum_nxt;
    target_r <= target_nxt;
    csel_r   <= csel_nxt;
    before_r <= before_nxt;
    cnt_o_r  <= cnt_o_nxt;
    sum_o_r  <= sum_o_nxt;
    lo_o_r   <= lo_o_nxt;
    up_o_r   <= up_o_nxt;
    mean_r   <= mean_nxt;
    pct_r    <= pct_nxt;
    ma_r     <= ma_nxt;
    mb_r     <= mb_nxt;
    mk_r     <= mk_nxt;
    acc_r    <= acc_nxt;
    tk_r     <= tk_nxt;
    trem_r   <= trem_nxt;
    tqd_r    <= tqd_nxt;
    tq_r     <= tq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      dsel_r   <= D_MEAN;
      gc_r     <= '0;
      gs_r     <= '0;
      min_r    <= MASK40;
      max_r    <= '0;
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      pv_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      dsel_r   <= dsel_nxt;
      gc_r     <= gc_nxt;
      gs_r     <= gs_nxt;
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      rd_vld_r <= vld_r[addr];
      pv_r     <= (state_r == S_MUL);
      if (clr_en)     vld_r <= '0;
      else if (wr_en) vld_r[addr] <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
    (gc_r != '0) |-> (min_r <= max_r)) else $error("min above max with samples");
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (idx_r < n_r)) else $error("bucket write beyond buckets in use");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> (state_r == S_DIV)) else $error("divider launched without wait");
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
`endif

endmodule
